// ===== hdl/rpbc_pkg.sv =====
// Shared types and constants for the box-center point rotator.
`timescale 1ns / 1ps

package rpbc_pkg;

  localparam int COORD_W = 32;
  localparam int ANGLE_W = 16;
  localparam int OP_W = 2;
  localparam int S_DATA_W = 3 * COORD_W + ANGLE_W;
  localparam int M_DATA_W = 3 * COORD_W;
  localparam int ADDR_W = 5;
  localparam int REG_IDX_W = 3;
  localparam int APB_DATA_W = 32;

  localparam int OFS_W = COORD_W + 1;
  localparam int XY_W = 34;
  localparam int Z_W = 33;
  localparam int TRIG_W = 31;
  localparam int PROD_W = OFS_W + TRIG_W;
  localparam int ROUND_W = PROD_W + 1 - 29;
  localparam int ATAN_ENTRIES = 24;

  localparam logic [OP_W-1:0] AXIS_X = 2'd0;
  localparam logic [OP_W-1:0] AXIS_Y = 2'd1;
  localparam logic [OP_W-1:0] AXIS_Z = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_MIN_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_X = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAX_Y = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MAX_Z = 3'd5;

  localparam logic [XY_W-1:0] CORDIC_GAIN = 34'h0_26DD_3B6A;
  localparam logic [47:0] PI_Q32 = 48'h0003_243F_6A89;
  localparam logic [47:0] ANGLE_ROUND = 48'h0000_0001_0000;
  localparam int ONE_Q29 = 2 ** 29;
  localparam int ROUND_Q29 = 2 ** 28;

  localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [COORD_W-1:0] pz;
    logic [COORD_W-1:0] ca;
    logic [COORD_W-1:0] cb;
    logic [OFS_W-1:0]   f;
    logic [OFS_W-1:0]   g;
    logic [1:0]         quad;
  } side_t;

endpackage

// ===== hdl/rotate_point_about_box_center.sv =====
// Top level of the point rotator about the bounding box center.
`timescale 1ns / 1ps

// Rotates a Q16.16 point about the line parallel to the selected axis (tuser: 0 x, 1 y, 2 z,
// 3 passes the point through) that runs through the center of the box set over APB.
// A new word is taken every cycle while the output is not stalled. Each word passes through
// one register stage per CORDIC iteration plus input, trig fixup, multiply, rounding and output
// stages; the input stage loads at the edge that takes the word.
// Box writes reach the datapath through the registered center values.
module rotate_point_about_box_center #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // point_x, point_y, point_z, turn_angle
  input  logic [rpbc_pkg::S_DATA_W-1:0]     s_tdata,
  // op
  input  logic [rpbc_pkg::OP_W-1:0]         s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // rotated_x, rotated_y, rotated_z
  output logic [rpbc_pkg::M_DATA_W-1:0]     m_tdata,
  // saturated
  output logic [0:0]                        m_tuser,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rpbc_pkg::ADDR_W-1:0]       paddr,
  input  logic [rpbc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rpbc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import rpbc_pkg::*;

  localparam logic signed [XY_W-1:0] TRIG_HI = XY_W'(ONE_Q29);
  localparam logic signed [XY_W-1:0] TRIG_LO = -TRIG_HI;

  logic [COORD_W-1:0] box_min [3];
  logic [COORD_W-1:0] box_max [3];
  logic [COORD_W-1:0] ctr [3];
  logic [REG_IDX_W-1:0] reg_idx;
  logic cfg_wr;

  assign pready = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        box_min[k] <= '0;
        box_max[k] <= '0;
        ctr[k] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        case (reg_idx)
          REG_MIN_X: box_min[0] <= pwdata;
          REG_MIN_Y: box_min[1] <= pwdata;
          REG_MIN_Z: box_min[2] <= pwdata;
          REG_MAX_X: box_max[0] <= pwdata;
          REG_MAX_Y: box_max[1] <= pwdata;
          REG_MAX_Z: box_max[2] <= pwdata;
          default: ;
        endcase
      end
      for (int k = 0; k < 3; k++) begin
        ctr[k] <= COORD_W'(({box_min[k][COORD_W-1], box_min[k]} +
                            {box_max[k][COORD_W-1], box_max[k]}) >> 1);
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MIN_X: prdata = box_min[0];
      REG_MIN_Y: prdata = box_min[1];
      REG_MIN_Z: prdata = box_min[2];
      REG_MAX_X: prdata = box_max[0];
      REG_MAX_Y: prdata = box_max[1];
      REG_MAX_Z: prdata = box_max[2];
      default:   prdata = '0;
    endcase
  end

  // Input stage: offsets from the center and the CORDIC start angle.
  side_t              in_side;
  logic [COORD_W-1:0] pa;
  logic [COORD_W-1:0] pb;
  logic [47:0]        ang_prod;
  logic signed [Z_W-1:0] in_z;

  always_comb begin
    in_side.op = s_tuser;
    in_side.px = s_tdata[COORD_W-1:0];
    in_side.py = s_tdata[2*COORD_W-1:COORD_W];
    in_side.pz = s_tdata[3*COORD_W-1:2*COORD_W];
    in_side.quad = s_tdata[S_DATA_W-1 -: 2];
    case (s_tuser)
      AXIS_X: begin
        pa = in_side.py;
        pb = in_side.pz;
        in_side.ca = ctr[1];
        in_side.cb = ctr[2];
      end
      AXIS_Y: begin
        pa = in_side.pz;
        pb = in_side.px;
        in_side.ca = ctr[2];
        in_side.cb = ctr[0];
      end
      default: begin
        pa = in_side.px;
        pb = in_side.py;
        in_side.ca = ctr[0];
        in_side.cb = ctr[1];
      end
    endcase
    in_side.f = {pa[COORD_W-1], pa} - {in_side.ca[COORD_W-1], in_side.ca};
    in_side.g = {pb[COORD_W-1], pb} - {in_side.cb[COORD_W-1], in_side.cb};
    ang_prod = 48'(s_tdata[S_DATA_W-3:3*COORD_W]) * PI_Q32 + ANGLE_ROUND;
    in_z = $signed(Z_W'(ang_prod[47:17]));
  end

  logic                  v0;
  side_t                 side0;
  logic signed [Z_W-1:0] z0;
  logic                  c_in_ready;
  logic                  rdy0;

  assign rdy0 = !v0 || c_in_ready;
  assign s_tready = rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (rdy0) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      side0 <= in_side;
      z0 <= in_z;
    end
  end

  logic                   c_out_valid;
  side_t                  c_side;
  logic signed [XY_W-1:0] c_x;
  logic signed [XY_W-1:0] c_y;
  logic                   rdy_p;

  rpbc_cordic #(
    .STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v0),
    .in_ready (c_in_ready),
    .in_side  (side0),
    .in_z     (z0),
    .out_valid(c_out_valid),
    .out_ready(rdy_p),
    .out_side (c_side),
    .out_x    (c_x),
    .out_y    (c_y)
  );

  // Trig stage: round to Q29, clamp to one, map by quadrant.
  logic signed [XY_W:0]     xr;
  logic signed [XY_W:0]     yr;
  logic signed [XY_W-1:0]   xh;
  logic signed [XY_W-1:0]   yh;
  logic signed [TRIG_W-1:0] cq;
  logic signed [TRIG_W-1:0] sq;
  logic signed [TRIG_W-1:0] co_next;
  logic signed [TRIG_W-1:0] si_next;

  always_comb begin
    xr = {c_x[XY_W-1], c_x} + (XY_W+1)'(1);
    yr = {c_y[XY_W-1], c_y} + (XY_W+1)'(1);
    xh = xr[XY_W:1];
    yh = yr[XY_W:1];
    if (xh > TRIG_HI) begin
      cq = TRIG_W'(TRIG_HI);
    end else if (xh < TRIG_LO) begin
      cq = TRIG_W'(TRIG_LO);
    end else begin
      cq = TRIG_W'(xh);
    end
    if (yh > TRIG_HI) begin
      sq = TRIG_W'(TRIG_HI);
    end else if (yh < TRIG_LO) begin
      sq = TRIG_W'(TRIG_LO);
    end else begin
      sq = TRIG_W'(yh);
    end
    case (c_side.quad)
      2'd0: begin
        co_next = cq;
        si_next = sq;
      end
      2'd1: begin
        co_next = -sq;
        si_next = cq;
      end
      2'd2: begin
        co_next = -cq;
        si_next = -sq;
      end
      default: begin
        co_next = sq;
        si_next = -cq;
      end
    endcase
  end

  logic                     vp;
  side_t                    side_p;
  logic signed [TRIG_W-1:0] co;
  logic signed [TRIG_W-1:0] si;
  logic                     rdy_m;

  assign rdy_p = !vp || rdy_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (rdy_p) begin
      vp <= c_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_p) begin
      side_p <= c_side;
      co <= co_next;
      si <= si_next;
    end
  end

  // Multiply stage.
  logic                     vm;
  side_t                    side_m;
  logic signed [PROD_W-1:0] fc;
  logic signed [PROD_W-1:0] gs;
  logic signed [PROD_W-1:0] fs;
  logic signed [PROD_W-1:0] gc;
  logic                     rdy_u;

  assign rdy_m = !vm || rdy_u;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (rdy_m) begin
      vm <= vp;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_m) begin
      side_m <= side_p;
      fc <= $signed(side_p.f) * co;
      gs <= $signed(side_p.g) * si;
      fs <= $signed(side_p.f) * si;
      gc <= $signed(side_p.g) * co;
    end
  end

  // Rounding stage.
  logic signed [PROD_W:0]    u_sum;
  logic signed [PROD_W:0]    v_sum;
  logic                      vu;
  side_t                     side_u;
  logic signed [ROUND_W-1:0] ua;
  logic signed [ROUND_W-1:0] vb;
  logic                      rdy_f;

  assign u_sum = {fc[PROD_W-1], fc} - {gs[PROD_W-1], gs} + (PROD_W+1)'(ROUND_Q29);
  assign v_sum = {fs[PROD_W-1], fs} + {gc[PROD_W-1], gc} + (PROD_W+1)'(ROUND_Q29);
  assign rdy_u = !vu || rdy_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      vu <= 1'b0;
    end else if (rdy_u) begin
      vu <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_u) begin
      side_u <= side_m;
      ua <= u_sum[PROD_W:29];
      vb <= v_sum[PROD_W:29];
    end
  end

  // Output stage: add the center back and saturate.
  logic [ROUND_W:0]   ra_full;
  logic [ROUND_W:0]   rb_full;
  logic               ra_ovf;
  logic               rb_ovf;
  logic [COORD_W-1:0] ra;
  logic [COORD_W-1:0] rb;
  logic [M_DATA_W-1:0] data_next;
  logic                sat_next;

  always_comb begin
    ra_full = {ua[ROUND_W-1], ua} + (ROUND_W+1)'($signed(side_u.ca));
    rb_full = {vb[ROUND_W-1], vb} + (ROUND_W+1)'($signed(side_u.cb));
    ra_ovf = (ra_full[ROUND_W:COORD_W-1] != '0) && (ra_full[ROUND_W:COORD_W-1] != '1);
    rb_ovf = (rb_full[ROUND_W:COORD_W-1] != '0) && (rb_full[ROUND_W:COORD_W-1] != '1);
    if (ra_ovf) begin
      ra = ra_full[ROUND_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      ra = ra_full[COORD_W-1:0];
    end
    if (rb_ovf) begin
      rb = rb_full[ROUND_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      rb = rb_full[COORD_W-1:0];
    end
    sat_next = ra_ovf || rb_ovf;
    case (side_u.op)
      AXIS_X: data_next = {rb, ra, side_u.px};
      AXIS_Y: data_next = {ra, side_u.py, rb};
      AXIS_Z: data_next = {side_u.pz, rb, ra};
      default: begin
        data_next = {side_u.pz, side_u.py, side_u.px};
        sat_next = 1'b0;
      end
    endcase
  end

  assign rdy_f = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rdy_f) begin
      m_tvalid <= vu;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_f) begin
      m_tdata <= data_next;
      m_tuser <= sat_next;
    end
  end

endmodule

// ===== hdl/rpbc_cordic.sv =====
// Pipelined rotation-mode CORDIC, one register stage per iteration.
`timescale 1ns / 1ps

module rpbc_cordic #(
  parameter int STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rpbc_pkg::side_t                   in_side,
  input  logic signed [rpbc_pkg::Z_W-1:0]   in_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rpbc_pkg::side_t                   out_side,
  output logic signed [rpbc_pkg::XY_W-1:0]  out_x,
  output logic signed [rpbc_pkg::XY_W-1:0]  out_y
);
  import rpbc_pkg::*;

  logic                   vld [STAGES];
  logic                   rdy [STAGES+1];
  logic signed [XY_W-1:0] xs  [STAGES];
  logic signed [XY_W-1:0] ys  [STAGES];
  logic signed [Z_W-1:0]  zs  [STAGES];
  side_t                  sd  [STAGES];

  assign rdy[STAGES] = out_ready;
  assign in_ready = rdy[0];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [XY_W-1:0] px;
    logic signed [XY_W-1:0] py;
    logic signed [Z_W-1:0]  pz;
    logic                   pv;
    side_t                  ps;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  da;

    if (i == 0) begin : g_first
      assign px = $signed(CORDIC_GAIN);
      assign py = '0;
      assign pz = in_z;
      assign pv = in_valid;
      assign ps = in_side;
    end else begin : g_rest
      assign px = xs[i-1];
      assign py = ys[i-1];
      assign pz = zs[i-1];
      assign pv = vld[i-1];
      assign ps = sd[i-1];
    end

    assign dx = py >>> i;
    assign dy = px >>> i;
    assign da = $signed(Z_W'(ATAN_Q30[i]));
    assign rdy[i] = !vld[i] || rdy[i+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        sd[i] <= ps;
        if (!pz[Z_W-1]) begin
          xs[i] <= px - dx;
          ys[i] <= py + dy;
          zs[i] <= pz - da;
        end else begin
          xs[i] <= px + dx;
          ys[i] <= py - dy;
          zs[i] <= pz + da;
        end
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign out_side = sd[STAGES-1];
  assign out_x = xs[STAGES-1];
  assign out_y = ys[STAGES-1];

endmodule

// ===== hdl/rpbc_checker.sv =====
// Port-level checks for the point rotator and the bind that attaches them.
`timescale 1ns / 1ps

module rpbc_checker #(
  parameter int CORDIC_STAGES = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [rpbc_pkg::M_DATA_W-1:0] m_tdata,
  input logic [0:0]                    m_tuser,
  input logic                          pready
);
  import rpbc_pkg::*;

  localparam int DEPTH = CORDIC_STAGES + 5;
  localparam int CNT_W = $clog2(DEPTH + 1) + 1;

  logic [CNT_W-1:0] inflight;
  logic [CNT_W-1:0] inflight_next;
  logic             in_acc;
  logic             out_acc;

  assign in_acc = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  always_comb begin
    inflight_next = inflight;
    if (in_acc && !out_acc) begin
      inflight_next = inflight + CNT_W'(1);
    end else if (out_acc && !in_acc) begin
      inflight_next = inflight - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  a_no_invented_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> inflight != '0)
    else $error("result word without a pending input word");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_W'(DEPTH))
    else $error("more words in flight than pipeline stages");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && pready)
    else $error("output valid right after reset");

endmodule

bind rotate_point_about_box_center rpbc_checker #(
  .CORDIC_STAGES(CORDIC_STAGES)
) u_rpbc_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .pready  (pready)
);
